// ===== hw/rtl/rsvg_pkg.sv =====
// shared types and constants for the rectangle set vertical gap block
`default_nettype none

package rsvg_pkg;

  // width of the two distance result fields
  localparam int OUT_BITS = 29;

  // no-overlap sentinel, 1000000.0 in Q20.8
  localparam int SENTINEL = 256000000;

  // input word kinds
  typedef enum logic {
    MODE_UPPER = 1'b0,
    MODE_LOWER = 1'b1
  } mode_t;

  // control bits traveling with a lower rectangle down the cell chain
  typedef struct packed {
    logic valid;
    logic last;
    logic tall;
    logic found;
  } wave_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsvg_cell.sv =====
// one cell of the chain: holds one upper rectangle and folds a passing lower one
`default_nettype none

module rsvg_cell #(
  parameter int COORD_BITS = 24,
  parameter int CNT_W      = 6,
  parameter int IDX        = 0
) (
  input  wire                           clk,
  input  wire                           rst,
  // store write port
  input  wire                           wr_req,
  input  wire        [CNT_W-1:0]        count,
  input  wire signed [COORD_BITS-1:0]   wr_left,
  input  wire signed [COORD_BITS-1:0]   wr_right,
  input  wire signed [COORD_BITS-1:0]   wr_bottom,
  // wave from the previous cell
  input  wire rsvg_pkg::wave_ctrl_t     ctrl_in,
  input  wire signed [COORD_BITS-1:0]   left_in,
  input  wire signed [COORD_BITS-1:0]   right_in,
  input  wire signed [COORD_BITS-1:0]   top_in,
  input  wire signed [COORD_BITS:0]     max_in,
  // wave to the next cell
  output rsvg_pkg::wave_ctrl_t          ctrl_out,
  output logic signed [COORD_BITS-1:0]  left_out,
  output logic signed [COORD_BITS-1:0]  right_out,
  output logic signed [COORD_BITS-1:0]  top_out,
  output logic signed [COORD_BITS:0]    max_out
);

  logic signed [COORD_BITS-1:0] ent_left;
  logic signed [COORD_BITS-1:0] ent_right;
  logic signed [COORD_BITS-1:0] ent_bottom;
  logic                         active;
  logic                         hit;
  logic                         take;
  logic signed [COORD_BITS:0]   gap;
  logic signed [COORD_BITS:0]   max_next;
  rsvg_pkg::wave_ctrl_t         ctrl_next;

  // entry is live while it lies below the fill count
  assign active = (count > CNT_W'(IDX));

  // entry write at the fill position
  always_ff @(posedge clk) begin
    if (wr_req && (count == CNT_W'(IDX))) begin
      ent_left   <= wr_left;
      ent_right  <= wr_right;
      ent_bottom <= wr_bottom;
    end
  end

  // strict horizontal overlap and gap fold
  always_comb begin
    hit = ctrl_in.valid && ctrl_in.tall && active &&
          (ent_left < right_in) && (left_in < ent_right);
    gap = (COORD_BITS+1)'(ent_bottom) - (COORD_BITS+1)'(top_in);
    take = hit && (!ctrl_in.found || (gap > max_in));
    max_next = take ? gap : max_in;
    ctrl_next = ctrl_in;
    ctrl_next.found = ctrl_in.found | hit;
  end

  // wave control stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else begin
      ctrl_out <= ctrl_next;
    end
  end

  // wave data stage
  always_ff @(posedge clk) begin
    left_out  <= left_in;
    right_out <= right_in;
    top_out   <= top_in;
    max_out   <= max_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rect_set_vertical_gap_core.sv =====
// top level: upper store in a chain of cells, lower rectangles walk the chain
// a lower word walks all MAX_UPPER_RECTS cells, one cell per cycle, and no further
// word, upper or lower, is taken until its wave has left the last cell
// the result word of a last lower word is registered from the wave at the chain exit
// lower words wait while a result word is still pending at the output
// synchronous reset empties the store, clears the flags and drops any pending result
`default_nettype none

module rect_set_vertical_gap_core #(
  parameter int MAX_UPPER_RECTS = 32,
  parameter int COORD_BITS      = 24
) (
  input  wire                                     clk,
  input  wire                                     rst,
  // input channel
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  wire                                     mode,
  input  wire signed [COORD_BITS-1:0]             rect_left,
  input  wire signed [COORD_BITS-1:0]             rect_right,
  input  wire signed [COORD_BITS-1:0]             rect_top,
  input  wire signed [COORD_BITS-1:0]             rect_bottom,
  input  wire                                     is_last,
  // output channel
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output logic signed [rsvg_pkg::OUT_BITS-1:0]    min_distance,
  output logic signed [rsvg_pkg::OUT_BITS-1:0]    clearance,
  output logic                                    any_overlap,
  output logic                                    overflow
);

  localparam int CNT_W = $clog2(MAX_UPPER_RECTS + 1);
  localparam int SW    = (COORD_BITS + 1 > 30) ? COORD_BITS + 1 : 30;
  localparam logic signed [SW-1:0] SENT = SW'(rsvg_pkg::SENTINEL);

  logic                       in_accept;
  logic                       tall;
  logic                       upper_write;
  logic                       busy;
  logic [CNT_W-1:0]           upper_count;
  logic                       upper_loaded;
  logic                       store_overflowed;
  logic                       pair_found;
  logic signed [COORD_BITS:0] running_max;

  rsvg_pkg::wave_ctrl_t         w_ctrl  [MAX_UPPER_RECTS+1];
  logic signed [COORD_BITS-1:0] w_left  [MAX_UPPER_RECTS+1];
  logic signed [COORD_BITS-1:0] w_right [MAX_UPPER_RECTS+1];
  logic signed [COORD_BITS-1:0] w_top   [MAX_UPPER_RECTS+1];
  logic signed [COORD_BITS:0]   w_max   [MAX_UPPER_RECTS+1];

  rsvg_pkg::wave_ctrl_t         exit_ctrl;
  logic signed [COORD_BITS:0]   exit_max;
  logic signed [SW-1:0]         max_ext;
  logic signed [SW-1:0]         max_sat;
  logic signed [rsvg_pkg::OUT_BITS-1:0] dist_next;
  logic signed [rsvg_pkg::OUT_BITS-1:0] clear_next;

  // input handshake: one lower word in the chain at a time
  assign in_stall  = busy || (out_valid && (mode == rsvg_pkg::MODE_LOWER));
  assign in_accept = in_valid && !in_stall;
  assign tall      = (rect_bottom > rect_top);
  assign upper_write = in_accept && (mode == rsvg_pkg::MODE_UPPER) && tall &&
                       (upper_count != CNT_W'(MAX_UPPER_RECTS));

  // wave injection at the head of the chain
  always_comb begin
    w_ctrl[0].valid = in_accept && (mode == rsvg_pkg::MODE_LOWER);
    w_ctrl[0].last  = is_last;
    w_ctrl[0].tall  = tall;
    w_ctrl[0].found = pair_found;
  end
  assign w_left[0]  = rect_left;
  assign w_right[0] = rect_right;
  assign w_top[0]   = rect_top;
  assign w_max[0]   = running_max;

  // the cell chain
  for (genvar k = 0; k < MAX_UPPER_RECTS; k++) begin : g_cell
    rsvg_cell #(
      .COORD_BITS (COORD_BITS),
      .CNT_W      (CNT_W),
      .IDX        (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_req    (upper_write),
      .count     (upper_count),
      .wr_left   (rect_left),
      .wr_right  (rect_right),
      .wr_bottom (rect_bottom),
      .ctrl_in   (w_ctrl[k]),
      .left_in   (w_left[k]),
      .right_in  (w_right[k]),
      .top_in    (w_top[k]),
      .max_in    (w_max[k]),
      .ctrl_out  (w_ctrl[k+1]),
      .left_out  (w_left[k+1]),
      .right_out (w_right[k+1]),
      .top_out   (w_top[k+1]),
      .max_out   (w_max[k+1])
    );
  end

  assign exit_ctrl = w_ctrl[MAX_UPPER_RECTS];
  assign exit_max  = w_max[MAX_UPPER_RECTS];

  // result values with saturation
  always_comb begin
    max_ext = SW'(exit_max);
    if (max_ext > SENT) begin
      max_sat = SENT;
    end else if (max_ext < -SENT) begin
      max_sat = -SENT;
    end else begin
      max_sat = max_ext;
    end
    if (!upper_loaded) begin
      dist_next  = '0;
      clear_next = '0;
    end else if (!exit_ctrl.found) begin
      dist_next  = rsvg_pkg::OUT_BITS'(-SENT);
      clear_next = rsvg_pkg::OUT_BITS'(SENT);
    end else begin
      dist_next  = rsvg_pkg::OUT_BITS'(max_sat);
      clear_next = rsvg_pkg::OUT_BITS'(-max_sat);
    end
  end

  // query state: busy flag, fill count, store flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      upper_count      <= '0;
      upper_loaded     <= 1'b0;
      store_overflowed <= 1'b0;
      pair_found       <= 1'b0;
    end else begin
      if (w_ctrl[0].valid) begin
        busy <= 1'b1;
      end else if (exit_ctrl.valid) begin
        busy <= 1'b0;
      end
      if (in_accept && (mode == rsvg_pkg::MODE_UPPER)) begin
        upper_loaded <= 1'b1;
        if (tall && (upper_count == CNT_W'(MAX_UPPER_RECTS))) begin
          store_overflowed <= 1'b1;
        end
      end
      if (upper_write) begin
        upper_count <= upper_count + CNT_W'(1);
      end
      if (exit_ctrl.valid) begin
        if (exit_ctrl.last) begin
          upper_count      <= '0;
          upper_loaded     <= 1'b0;
          store_overflowed <= 1'b0;
          pair_found       <= 1'b0;
        end else begin
          pair_found <= exit_ctrl.found;
        end
      end
    end
  end

  // running maximum follows the wave
  always_ff @(posedge clk) begin
    if (exit_ctrl.valid) begin
      running_max <= exit_max;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exit_ctrl.valid && exit_ctrl.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exit_ctrl.valid && exit_ctrl.last) begin
      min_distance <= dist_next;
      clearance    <= clear_next;
      any_overlap  <= upper_loaded && exit_ctrl.found;
      overflow     <= store_overflowed;
    end
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_accept)
    else $error("word accepted while a lower word walks the chain");

  a_exit_in_flight: assert property (@(posedge clk) disable iff (rst)
    exit_ctrl.valid |-> busy)
    else $error("wave left the chain with no word in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    upper_count <= CNT_W'(MAX_UPPER_RECTS))
    else $error("fill count beyond store depth");

  a_result_no_clash: assert property (@(posedge clk) disable iff (rst)
    (exit_ctrl.valid && exit_ctrl.last) |-> !out_valid)
    else $error("new result while previous one still pending");

  a_clearance_mirror: assert property (@(posedge clk) disable iff (rst)
    (out_valid && any_overlap) |-> (clearance == -min_distance))
    else $error("clearance is not the negated distance");

endmodule

`default_nettype wire
